FILE: rtl/qth_pkg.sv
// Shared constants and the arctangent table for the quaternion heading pipeline.
`timescale 1ns / 1ps

package qth_pkg;

   localparam int QUAT_BITS_DEF  = 16;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int POS_BITS       = 32;
   localparam int ANG_W          = 32;
   localparam int CORDIC_STEPS   = 30;
   localparam int NORM_BIT       = 44;

   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [ANG_W-1:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

endpackage

FILE: rtl/quaternion_to_heading.sv
// Top level: pipelined quaternion to heading converter with position pass-through.
// Stages: products, sum and difference, normalization (at QUAT_BITS above 21), pre-rotation,
// CORDIC (each iteration owns one pipeline stage), output. One transaction per cycle
// while not stalled; a stalled output freezes every stage, so none is dropped or repeated.
// Reset clears all valid bits and sets the heading offset to a half turn.
`timescale 1ns / 1ps

module quaternion_to_heading #(
   parameter int QUAT_BITS  = qth_pkg::QUAT_BITS_DEF,
   parameter int ANGLE_BITS = qth_pkg::ANGLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // quat_w, quat_x, quat_y, quat_z, pos_x, pos_y
   input  logic [((4*QUAT_BITS+2*qth_pkg::POS_BITS+7)/8)*8-1:0] req_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [ANGLE_BITS-1:0] csr_data,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_pos_x, out_pos_y, heading
   output logic [((2*qth_pkg::POS_BITS+ANGLE_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int OUT_W = ((2*qth_pkg::POS_BITS+ANGLE_BITS+7)/8)*8;
   localparam int PS    = (QUAT_BITS > 31) ? 2 : 0;
   localparam int MW    = 2*QUAT_BITS;
   localparam int PW    = MW - PS;
   localparam int VW    = PW + 3;
   localparam int NLIM  = qth_pkg::NORM_BIT + 1;
   localparam int NW    = (VW > NLIM) ? NLIM : VW;
   localparam int NS    = (VW > NLIM) ? $clog2(VW - qth_pkg::NORM_BIT + 1) : 0;
   localparam int CW    = NW + 3;
   localparam int STEPS = qth_pkg::CORDIC_STEPS;
   localparam int AW    = qth_pkg::ANG_W;
   localparam int RW    = AW + 2;
   localparam logic [ANGLE_BITS-1:0] OFFSET_RESET = {1'b1, {(ANGLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                            valid;
      logic                            zero;
      logic [2*qth_pkg::POS_BITS-1:0]  pos;
   } side_type;

   logic en;

   logic [ANGLE_BITS-1:0] offset_in, offset_ff;

   logic signed [QUAT_BITS-1:0] q_w, q_x, q_y, q_z;
   logic signed [MW-1:0] m_ww, m_xx, m_yy, m_zz, m_xy, m_wz;
   logic signed [PW-1:0] p_ww_in, p_xx_in, p_yy_in, p_zz_in, p_xy_in, p_wz_in;
   logic signed [PW-1:0] p_ww_ff, p_xx_ff, p_yy_ff, p_zz_ff, p_xy_ff, p_wz_ff;
   side_type mside_in, mside_ff;

   logic signed [VW-1:0] sum_a;
   logic signed [VW-1:0] nx_in [0:NS];
   logic signed [VW-1:0] ny_in [0:NS];
   logic signed [VW-1:0] nx_ff [0:NS];
   logic signed [VW-1:0] ny_ff [0:NS];
   side_type nside_in [0:NS];
   side_type nside_ff [0:NS];

   logic signed [CW-1:0] pre_x, pre_y;
   logic signed [CW-1:0] cx_in [0:STEPS];
   logic signed [CW-1:0] cy_in [0:STEPS];
   logic signed [CW-1:0] cx_ff [0:STEPS];
   logic signed [CW-1:0] cy_ff [0:STEPS];
   logic [AW-1:0] ca_in [0:STEPS];
   logic [AW-1:0] ca_ff [0:STEPS];
   side_type cside_in [0:STEPS];
   side_type cside_ff [0:STEPS];

   logic [AW-1:0] fin_ang;
   logic [RW-1:0] fin_round;
   logic [ANGLE_BITS-1:0] heading_in, heading_ff;
   logic rsp_valid_in, rsp_valid_ff;
   logic [2*qth_pkg::POS_BITS-1:0] rsp_pos_in, rsp_pos_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({heading_ff, rsp_pos_ff});

   assign offset_in = csr_valid ? csr_data : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      q_w  = $signed(req_tdata[0 +: QUAT_BITS]);
      q_x  = $signed(req_tdata[QUAT_BITS +: QUAT_BITS]);
      q_y  = $signed(req_tdata[2*QUAT_BITS +: QUAT_BITS]);
      q_z  = $signed(req_tdata[3*QUAT_BITS +: QUAT_BITS]);
      m_ww = MW'(q_w) * MW'(q_w);
      m_xx = MW'(q_x) * MW'(q_x);
      m_yy = MW'(q_y) * MW'(q_y);
      m_zz = MW'(q_z) * MW'(q_z);
      m_xy = MW'(q_x) * MW'(q_y);
      m_wz = MW'(q_w) * MW'(q_z);
      p_ww_in = PW'(m_ww >>> PS);
      p_xx_in = PW'(m_xx >>> PS);
      p_yy_in = PW'(m_yy >>> PS);
      p_zz_in = PW'(m_zz >>> PS);
      p_xy_in = PW'(m_xy >>> PS);
      p_wz_in = PW'(m_wz >>> PS);
      mside_in.valid = req_tvalid;
      mside_in.zero  = 1'b0;
      mside_in.pos   = req_tdata[4*QUAT_BITS +: 2*qth_pkg::POS_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mside_ff.valid <= 1'b0;
      end else if (en) begin
         mside_ff <= mside_in;
      end
      if (en) begin
         p_ww_ff <= p_ww_in;
         p_xx_ff <= p_xx_in;
         p_yy_ff <= p_yy_in;
         p_zz_ff <= p_zz_in;
         p_xy_ff <= p_xy_in;
         p_wz_ff <= p_wz_in;
      end
   end

   always_comb begin
      sum_a       = VW'(p_xy_ff) + VW'(p_wz_ff);
      nx_in[0]    = sum_a <<< 1;
      ny_in[0]    = (VW'(p_xx_ff) + VW'(p_zz_ff)) - (VW'(p_ww_ff) + VW'(p_yy_ff));
      nside_in[0] = mside_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nside_ff[0].valid <= 1'b0;
      end else if (en) begin
         nside_ff[0] <= nside_in[0];
      end
      if (en) begin
         nx_ff[0] <= nx_in[0];
         ny_ff[0] <= ny_in[0];
      end
   end

   for (genvar s = 1; s <= NS; s++) begin : g_norm
      localparam int B   = NS - s;
      localparam int TRY = (1 << B) - 1;
      localparam logic signed [VW-1:0] NORM_POS = VW'(1) <<< qth_pkg::NORM_BIT;
      localparam logic signed [VW-1:0] NORM_NEG = -NORM_POS;
      logic signed [VW-1:0] t_x, t_y;
      logic big;

      always_comb begin
         t_x = nx_ff[s-1] >>> TRY;
         t_y = ny_ff[s-1] >>> TRY;
         big = (t_x >= NORM_POS) || (t_x <= NORM_NEG) ||
               (t_y >= NORM_POS) || (t_y <= NORM_NEG);
         nx_in[s]    = big ? (nx_ff[s-1] >>> (1 << B)) : nx_ff[s-1];
         ny_in[s]    = big ? (ny_ff[s-1] >>> (1 << B)) : ny_ff[s-1];
         nside_in[s] = nside_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nside_ff[s].valid <= 1'b0;
         end else if (en) begin
            nside_ff[s] <= nside_in[s];
         end
         if (en) begin
            nx_ff[s] <= nx_in[s];
            ny_ff[s] <= ny_in[s];
         end
      end
   end

   always_comb begin
      pre_x = CW'(nx_ff[NS]);
      pre_y = CW'(ny_ff[NS]);
      cside_in[0]      = nside_ff[NS];
      cside_in[0].zero = (nx_ff[NS] == '0) && (ny_ff[NS] == '0);
      if (pre_x[CW-1]) begin
         cx_in[0] = -pre_x;
         cy_in[0] = -pre_y;
         ca_in[0] = qth_pkg::HALF_TURN;
      end else begin
         cx_in[0] = pre_x;
         cy_in[0] = pre_y;
         ca_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cside_ff[0].valid <= 1'b0;
      end else if (en) begin
         cside_ff[0] <= cside_in[0];
      end
      if (en) begin
         cx_ff[0] <= cx_in[0];
         cy_ff[0] <= cy_in[0];
         ca_ff[0] <= ca_in[0];
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_cordic
      logic signed [CW-1:0] xs, ys;

      always_comb begin
         xs = cx_ff[i] >>> i;
         ys = cy_ff[i] >>> i;
         cside_in[i+1] = cside_ff[i];
         if (!cy_ff[i][CW-1]) begin
            cx_in[i+1] = cx_ff[i] + ys;
            cy_in[i+1] = cy_ff[i] - xs;
            ca_in[i+1] = ca_ff[i] + qth_pkg::ATAN_TABLE[i];
         end else begin
            cx_in[i+1] = cx_ff[i] - ys;
            cy_in[i+1] = cy_ff[i] + xs;
            ca_in[i+1] = ca_ff[i] - qth_pkg::ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cside_ff[i+1].valid <= 1'b0;
         end else if (en) begin
            cside_ff[i+1] <= cside_in[i+1];
         end
         if (en) begin
            cx_ff[i+1] <= cx_in[i+1];
            cy_ff[i+1] <= cy_in[i+1];
            ca_ff[i+1] <= ca_in[i+1];
         end
      end
   end

   always_comb begin
      fin_ang      = cside_ff[STEPS].zero ? '0 : ca_ff[STEPS];
      fin_round    = {1'b0, fin_ang, 1'b0} + (RW'(1) << (AW - ANGLE_BITS));
      heading_in   = fin_round[RW-1-ANGLE_BITS +: ANGLE_BITS] + offset_ff;
      rsp_valid_in = cside_ff[STEPS].valid;
      rsp_pos_in   = cside_ff[STEPS].pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (en) begin
         heading_ff <= heading_in;
         rsp_pos_ff <= rsp_pos_in;
      end
   end

`ifndef SYNTH
   a_offset_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> offset_ff == OFFSET_RESET)
      else $error("Heading offset did not come out of reset as a half turn.");

   a_cordic_x_positive: assert property (@(posedge clock) disable iff (reset)
      cside_ff[STEPS].valid |-> !cx_ff[STEPS][CW-1])
      else $error("CORDIC x component went negative.");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      en && cside_ff[STEPS].valid && cside_ff[STEPS].zero |=>
      heading_ff == $past(offset_ff))
      else $error("A zero vector transaction did not return the heading offset.");
`endif

endmodule
